// ===== rtl/tcgr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants of the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

	localparam int FONT_BYTES_DEF       = 16384;
	localparam int MAX_GLYPH_HEIGHT_DEF = 32;

	// Internal font address width: covers the largest store and glyph offsets.
	localparam int FA_W = 17;

	localparam logic [1:0] CMD_LOAD_FONT  = 2'd0;
	localparam logic [1:0] CMD_PUT_CHAR   = 2'd1;
	localparam logic [1:0] CMD_SET_CURSOR = 2'd2;

	localparam logic [2:0] REG_GLYPH_WIDTH      = 3'd0;
	localparam logic [2:0] REG_GLYPH_HEIGHT     = 3'd1;
	localparam logic [2:0] REG_GLYPH_COUNT      = 3'd2;
	localparam logic [2:0] REG_BYTES_PER_GLYPH  = 3'd3;
	localparam logic [2:0] REG_LINE_PITCH       = 3'd4;
	localparam logic [2:0] REG_SCREEN_WIDTH     = 3'd5;
	localparam logic [2:0] REG_SCREEN_HEIGHT    = 3'd6;
	localparam logic [2:0] REG_BACKGROUND_COLOR = 3'd7;

	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_DEL = 8'd127;

	typedef struct packed {
		logic [1:0]  command;
		logic [13:0] font_address;
		logic [7:0]  font_byte;
		logic [7:0]  char_code;
		logic [7:0]  new_column;
		logic [7:0]  new_line;
	} in_item_t;

	typedef struct packed {
		logic [27:0] row_address;
		logic [15:0] pixel_bits;
		logic [7:0]  column_after;
		logic [7:0]  line_after;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic            en;
		logic [FA_W-1:0] addr;
		logic [7:0]      data;
	} font_wr_t;

	typedef struct packed {
		logic            en;
		logic [FA_W-1:0] addr;
	} font_rd_t;

endpackage

// ===== rtl/text_console_glyph_renderer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top
// Text console: loads a bitmap font, keeps a cursor and turns characters
// into one framebuffer row beat per glyph row.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  in       | in_valid / in_ready   | in_item  (command, font, char, cursor)
//  out      | out_valid / out_ready | out_item (row offset, mask, cursor)
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// Load, set-cursor and unknown commands stay in the idle state. A drawn or
// blanked character goes through accept, cursor update, BASE1 and BASE2
// address states, then one row beat per row (a font store read for drawn
// ones) through the font read and output registers. Font store reads both
// bytes of a row in one access. Output stalls hold the row sequencer. Reset
// sets cursor to 0 and registers to defaults; font store is not cleared.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top
	import tcgr_pkg::*;
#(
	parameter int FONT_BYTES       = FONT_BYTES_DEF,
	parameter int MAX_GLYPH_HEIGHT = MAX_GLYPH_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int ROW_CAP = (MAX_GLYPH_HEIGHT < 32) ? MAX_GLYPH_HEIGHT : 32;
	localparam logic [5:0] ROW_CAP_V = 6'(ROW_CAP);
	localparam logic [FA_W-1:0] FONT_LIMIT = FA_W'(FONT_BYTES);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_BASE1 = 3'd2;
	localparam logic [2:0] ST_BASE2 = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;

	logic [4:0]  gw_q;
	logic [5:0]  gh_q;
	logic [8:0]  gc_q;
	logic [6:0]  bpg_q;
	logic [15:0] pitch_q;
	logic [11:0] sw_q;
	logic [11:0] sh_q;

	logic [7:0] col_q;
	logic [7:0] line_q;

	logic [7:0]  char_q;
	logic [7:0]  draw_col_q;
	logic [7:0]  draw_line_q;
	logic        blank_q;
	logic [7:0]  gidx_q;
	logic [5:0]  rows_q;
	logic [13:0] lh_q;
	logic [12:0] cw_q;
	logic [14:0] gbase_q;
	logic [27:0] row_addr_q;
	logic [FA_W-1:0] rd_addr_q;
	logic [5:0]  cnt_q;

	logic        s1_v;
	out_item_t   s1_item;
	logic        s1_blank;
	logic        s1_bpl2;
	logic [4:0]  s1_sh;
	logic        out_v;
	out_item_t   out_q;

	logic        in_acc;
	logic [4:0]  w_eff;
	logic        bpl2;
	logic [5:0]  rows_eff;
	logic [8:0]  col_p2;
	logic [8:0]  line_p2;
	logic [13:0] col_span;
	logic [15:0] line_span;
	logic        wrap;
	logic        drop;
	logic [7:0]  col_w;
	logic [7:0]  line_w;
	logic [7:0]  col_bs;
	logic        is_bs;
	logic        last_row;
	logic        issue;
	logic        s1_move;
	logic [29:0] line_off;
	logic [7:0]  font_lo;
	logic [7:0]  font_hi;
	logic [15:0] row_word;
	font_wr_t    font_wr;
	font_rd_t    font_rd;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (gw_q == 5'd0) begin
			w_eff = 5'd1;
		end else if (gw_q > 5'd16) begin
			w_eff = 5'd16;
		end else begin
			w_eff = gw_q;
		end
	end
	assign bpl2     = w_eff > 5'd8;
	assign rows_eff = (gh_q > ROW_CAP_V) ? ROW_CAP_V : gh_q;

	// col >= floor(sw / (w+1)) - 1  <=>  (col + 2) * (w + 1) > sw
	assign col_p2    = {1'b0, col_q} + 9'd2;
	assign line_p2   = {1'b0, line_q} + 9'd2;
	assign col_span  = 14'(col_p2) * 14'(w_eff + 5'd1);
	assign line_span = 16'(line_p2) * 16'({1'b0, gh_q} + 7'd1);
	assign wrap      = col_span > 14'(sw_q);
	assign drop      = wrap && (line_span > 16'(sh_q));
	assign col_w     = wrap ? 8'd0 : col_q;
	assign line_w    = wrap ? line_q + 8'd1 : line_q;
	assign col_bs    = (col_w != 8'd0) ? col_w - 8'd1 : 8'd0;
	assign is_bs     = (char_q == CH_BS) || (char_q == CH_DEL);

	assign last_row = (cnt_q == rows_q - 6'd1);
	assign s1_move  = s1_v && (!out_v || out_ready);
	assign issue    = (state_q == ST_EMIT) && (!s1_v || s1_move);
	assign line_off = 30'(lh_q) * 30'(pitch_q);

	assign font_wr = '{en:   in_acc && (in_item.command == CMD_LOAD_FONT)
	                         && (FA_W'(in_item.font_address) < FONT_LIMIT),
	                   addr: FA_W'(in_item.font_address),
	                   data: in_item.font_byte};
	assign font_rd = '{en: issue && !blank_q, addr: rd_addr_q};

	tcgr_font_store #(
		.FONT_BYTES(FONT_BYTES)
	) u_font (
		.clk(clk),
		.wr (font_wr),
		.rd (font_rd),
		.lo (font_lo),
		.hi (font_hi)
	);

	assign row_word = s1_bpl2 ? {font_lo, font_hi} : {8'd0, font_lo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= 8'd0;
			line_q  <= 8'd0;
			gw_q    <= 5'd8;
			gh_q    <= 6'd16;
			gc_q    <= 9'd256;
			bpg_q   <= 7'd16;
			pitch_q <= 16'd4096;
			sw_q    <= 12'd1024;
			sh_q    <= 12'd768;
			s1_v    <= 1'b0;
			out_v   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_GLYPH_WIDTH:     gw_q    <= cfg_data[4:0];
					REG_GLYPH_HEIGHT:    gh_q    <= cfg_data[5:0];
					REG_GLYPH_COUNT:     gc_q    <= cfg_data[8:0];
					REG_BYTES_PER_GLYPH: bpg_q   <= cfg_data[6:0];
					REG_LINE_PITCH:      pitch_q <= cfg_data[15:0];
					REG_SCREEN_WIDTH:    sw_q    <= cfg_data[11:0];
					REG_SCREEN_HEIGHT:   sh_q    <= cfg_data[11:0];
					// painting happens downstream; nothing kept here
					REG_BACKGROUND_COLOR: ;
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_item.command == CMD_SET_CURSOR) begin
						col_q  <= in_item.new_column;
						line_q <= in_item.new_line;
					end else if (in_acc && in_item.command == CMD_PUT_CHAR) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_IDLE;
					if (!drop) begin
						if (char_q == CH_CR) begin
							col_q  <= 8'd0;
							line_q <= line_w;
						end else if (char_q == CH_LF) begin
							col_q  <= 8'd0;
							line_q <= line_w + 8'd1;
						end else begin
							col_q  <= is_bs ? col_bs : col_w + 8'd1;
							line_q <= line_w;
							if (rows_eff != 6'd0) begin
								state_q <= ST_BASE1;
							end
						end
					end
				end
				ST_BASE1: state_q <= ST_BASE2;
				ST_BASE2: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (issue && last_row) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (issue) begin
				s1_v <= 1'b1;
			end else if (s1_move) begin
				s1_v <= 1'b0;
			end

			if (s1_move) begin
				out_v <= 1'b1;
			end else if (out_ready) begin
				out_v <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_q <= in_item.char_code;
		end
		if (state_q == ST_PREP) begin
			draw_col_q  <= is_bs ? col_bs : col_w;
			draw_line_q <= line_w;
			blank_q     <= is_bs;
			gidx_q      <= ({1'b0, char_q} < gc_q) ? char_q : 8'd0;
			rows_q      <= rows_eff;
		end
		if (state_q == ST_BASE1) begin
			lh_q    <= 14'(draw_line_q) * 14'(gh_q);
			cw_q    <= 13'(draw_col_q) * 13'(w_eff + 5'd1);
			gbase_q <= 15'(gidx_q) * 15'(bpg_q);
		end
		if (state_q == ST_BASE2) begin
			row_addr_q <= line_off[27:0] + {13'd0, cw_q, 2'b00};
			rd_addr_q  <= FA_W'(gbase_q);
			cnt_q      <= 6'd0;
		end
		if (issue) begin
			row_addr_q           <= row_addr_q + 28'(pitch_q);
			rd_addr_q            <= rd_addr_q + (bpl2 ? FA_W'(2) : FA_W'(1));
			cnt_q                <= cnt_q + 6'd1;
			s1_item.row_address  <= row_addr_q;
			s1_item.pixel_bits   <= 16'd0;
			s1_item.column_after <= col_q;
			s1_item.line_after   <= line_q;
			s1_item.last         <= last_row;
			s1_blank             <= blank_q;
			s1_bpl2              <= bpl2;
			s1_sh                <= bpl2 ? 5'd16 - w_eff : 5'd8 - w_eff;
		end
		if (s1_move) begin
			out_q            <= s1_item;
			out_q.pixel_bits <= s1_blank ? 16'd0 : (row_word >> s1_sh);
		end
	end

	assign out_valid = out_v;
	assign out_item  = out_q;

endmodule

// ===== rtl/tcgr_font_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgr_font_store
// Font byte store split in even and odd banks, so a read returns the bytes
// at addr and addr+1 together. Out-of-range bytes read as zero.
// ----------------------------------------------------------------------------
module tcgr_font_store
	import tcgr_pkg::*;
#(
	parameter int FONT_BYTES = FONT_BYTES_DEF
) (
	input  logic       clk,
	input  font_wr_t   wr,
	input  font_rd_t   rd,
	output logic [7:0] lo,
	output logic [7:0] hi
);

	localparam int BANK_DEPTH = (FONT_BYTES + 1) / 2;
	localparam int BI_W       = $clog2(BANK_DEPTH);
	localparam logic [FA_W-1:0] LIMIT = FA_W'(FONT_BYTES);

	logic [7:0] bank_e [BANK_DEPTH];
	logic [7:0] bank_o [BANK_DEPTH];

	logic [FA_W-1:0] addr_n;
	logic [FA_W-1:0] idx_e;
	logic [FA_W-1:0] idx_o;
	logic [FA_W-1:0] wr_idx;

	logic [7:0] rd_e_q;
	logic [7:0] rd_o_q;
	logic       odd_q;
	logic       lo_ok_q;
	logic       hi_ok_q;

	assign addr_n = rd.addr + FA_W'(1);
	// even bank holds whichever of addr / addr+1 is even
	assign idx_e  = addr_n >> 1;
	assign idx_o  = rd.addr >> 1;
	assign wr_idx = wr.addr >> 1;

	always_ff @(posedge clk) begin
		if (wr.en && !wr.addr[0]) begin
			bank_e[wr_idx[BI_W-1:0]] <= wr.data;
		end
		if (wr.en && wr.addr[0]) begin
			bank_o[wr_idx[BI_W-1:0]] <= wr.data;
		end
		if (rd.en) begin
			rd_e_q  <= bank_e[idx_e[BI_W-1:0]];
			rd_o_q  <= bank_o[idx_o[BI_W-1:0]];
			odd_q   <= rd.addr[0];
			lo_ok_q <= rd.addr < LIMIT;
			hi_ok_q <= addr_n < LIMIT;
		end
	end

	assign lo = lo_ok_q ? (odd_q ? rd_o_q : rd_e_q) : 8'd0;
	assign hi = hi_ok_q ? (odd_q ? rd_e_q : rd_o_q) : 8'd0;

endmodule

// ===== dv/text_console_glyph_renderer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top_test
// Self-checking bench for the text console glyph renderer. A software
// console model tracks the font bytes, cursor and registers, predicts every
// row beat of each accepted command and checks the output stream in order.
// Runs a short directed sequence, then random command streams under several
// register settings and handshake idle/stall mixes.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top_test;
	import tcgr_pkg::*;

	class console_model;
		bit [7:0]  font_mem [FONT_BYTES_DEF];
		bit [7:0]  cur_col;
		bit [7:0]  cur_line;
		bit [4:0]  gw;
		bit [5:0]  gh;
		bit [8:0]  gcount;
		bit [6:0]  bpg;
		bit [15:0] pitch;
		bit [11:0] sw;
		bit [11:0] sh;
		bit [31:0] bg;
		out_item_t pending_rows[$];
		int        mismatches;

		function new();
			gw = 8;
			gh = 16;
			gcount = 256;
			bpg = 16;
			pitch = 4096;
			sw = 1024;
			sh = 768;
			bg = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_GLYPH_WIDTH:      gw = data[4:0];
				REG_GLYPH_HEIGHT:     gh = data[5:0];
				REG_GLYPH_COUNT:      gcount = data[8:0];
				REG_BYTES_PER_GLYPH:  bpg = data[6:0];
				REG_LINE_PITCH:       pitch = data[15:0];
				REG_SCREEN_WIDTH:     sw = data[11:0];
				REG_SCREEN_HEIGHT:    sh = data[11:0];
				REG_BACKGROUND_COLOR: bg = data;
				default: ;
			endcase
		endfunction

		// width 0 acts as 1, anything above 16 as 16
		function int unsigned glyph_px();
			if (gw == 0)
				return 1;
			if (gw > 16)
				return 16;
			return gw;
		endfunction

		function int unsigned row_count();
			if (gh > MAX_GLYPH_HEIGHT_DEF)
				return MAX_GLYPH_HEIGHT_DEF;
			return gh;
		endfunction

		function int col_limit();
			return int'(sw / (glyph_px() + 1));
		endfunction

		function int line_limit();
			return int'(sh / (gh + 32'd1));
		endfunction

		function int unsigned stored(int unsigned a);
			return (a < FONT_BYTES_DEF) ? font_mem[a] : 0;
		endfunction

		function void queue_rows(bit [7:0] col, bit [7:0] line, bit blank, int unsigned gbase);
			out_item_t       row;
			longint unsigned base, addr, cl, ln, hgt, pch;
			int unsigned     w, rows, bpl, v;
			w = glyph_px();
			rows = row_count();
			bpl = (w + 7) / 8;
			cl = col;
			ln = line;
			hgt = gh;
			pch = pitch;
			// raw height, not the capped row count, sets the line stride
			base = ln * hgt * pch + cl * (w + 1) * 4;
			for (int unsigned r = 0; r < rows; r++) begin
				v = 0;
				if (!blank) begin
					v = stored(gbase + r * bpl);
					if (bpl == 2)
						v = (v << 8) | stored(gbase + r * bpl + 1);
					v = v >> (bpl * 8 - w);
				end
				addr = base + r * pch;
				row.row_address = addr[27:0];
				row.pixel_bits = v[15:0];
				row.column_after = cur_col;
				row.line_after = cur_line;
				row.last = (r + 1 == rows);
				pending_rows.push_back(row);
			end
		endfunction

		function void put_char(bit [7:0] code);
			int          col_now, line_now;
			bit [7:0]    col_at;
			int unsigned idx;
			col_now = cur_col;
			line_now = cur_line;
			if (col_now >= col_limit() - 1) begin
				if (line_now >= line_limit() - 1)
					return;
				cur_col = 0;
				cur_line++;
			end
			case (code)
				CH_CR: cur_col = 0;
				CH_LF: begin
					cur_col = 0;
					cur_line++;
				end
				CH_BS, CH_DEL: begin
					if (cur_col != 0)
						cur_col--;
					queue_rows(cur_col, cur_line, 1'b1, 0);
				end
				default: begin
					col_at = cur_col;
					idx = (code < gcount) ? code : 0;
					cur_col++;
					queue_rows(col_at, cur_line, 1'b0, idx * bpg);
				end
			endcase
		endfunction

		function void take_command(in_item_t cmd);
			case (cmd.command)
				CMD_LOAD_FONT:  font_mem[cmd.font_address] = cmd.font_byte;
				CMD_PUT_CHAR:   put_char(cmd.char_code);
				CMD_SET_CURSOR: begin
					cur_col = cmd.new_column;
					cur_line = cmd.new_line;
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			if (mismatches < 40)
				$display("%0t mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task match_row(out_item_t got);
			out_item_t want;
			if (pending_rows.size() == 0) begin
				report($sformatf("unexpected row beat %h", got));
				return;
			end
			want = pending_rows.pop_front();
			if (got.row_address !== want.row_address)
				report($sformatf("row_address %h, want %h", got.row_address, want.row_address));
			if (got.pixel_bits !== want.pixel_bits)
				report($sformatf("pixel_bits %h, want %h", got.pixel_bits, want.pixel_bits));
			if (got.column_after !== want.column_after)
				report($sformatf("column_after %0d, want %0d", got.column_after,
					want.column_after));
			if (got.line_after !== want.line_after)
				report($sformatf("line_after %0d, want %0d", got.line_after, want.line_after));
			if (got.last !== want.last)
				report($sformatf("last %b, want %b", got.last, want.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	int           send_idle_pct = 0;
	int           stall_pct = 0;
	bit           font_written [FONT_BYTES_DEF];
	bit [7:0]     glyph_pool [6];
	bit [7:0]     ctrl_codes [4] = '{CH_CR, CH_LF, CH_BS, CH_DEL};
	console_model sb = new();

	text_console_glyph_renderer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.match_row(out_item);
	end

	initial begin
		#2_000_000;
		$display("FAIL text_console_glyph_renderer_top");
		$finish;
	end

	// unused fields carry random filler
	function in_item_t filler_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[47:0];
	endfunction

	function int clip8(int v);
		if (v < 0)
			return 0;
		if (v > 255)
			return 255;
		return v;
	endfunction

	task push_command(in_item_t cmd);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_item = cmd;
		do @(posedge clk); while (!in_ready);
		sb.take_command(cmd);
	endtask

	task load_byte(int unsigned addr, int unsigned data);
		in_item_t cmd;
		cmd = filler_item();
		cmd.command = CMD_LOAD_FONT;
		cmd.font_address = addr[13:0];
		cmd.font_byte = data[7:0];
		font_written[addr[13:0]] = 1'b1;
		push_command(cmd);
	endtask

	// the renderer must never read a font byte that was not loaded
	task load_glyph(bit [7:0] code);
		int unsigned idx, bpl, a;
		if (code == CH_CR || code == CH_LF || code == CH_BS || code == CH_DEL)
			return;
		idx = (code < sb.gcount) ? code : 0;
		bpl = (sb.glyph_px() + 7) / 8;
		for (int unsigned r = 0; r < sb.row_count(); r++) begin
			for (int unsigned b = 0; b < bpl; b++) begin
				a = idx * sb.bpg + r * bpl + b;
				if (a < FONT_BYTES_DEF && !font_written[a])
					load_byte(a, $urandom_range(255));
			end
		end
	endtask

	task type_char(bit [7:0] code);
		in_item_t cmd;
		load_glyph(code);
		cmd = filler_item();
		cmd.command = CMD_PUT_CHAR;
		cmd.char_code = code;
		push_command(cmd);
	endtask

	task set_cursor(int col, int line);
		in_item_t cmd;
		cmd = filler_item();
		cmd.command = CMD_SET_CURSOR;
		cmd.new_column = col[7:0];
		cmd.new_line = line[7:0];
		push_command(cmd);
	endtask

	task odd_command();
		in_item_t cmd;
		cmd = filler_item();
		cmd.command = ~CMD_LOAD_FONT;
		push_command(cmd);
	endtask

	task write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	task configure(int w, int h, int count, int bytes, int lp, int swid, int shgt,
			logic [31:0] bgc);
		write_reg(REG_GLYPH_WIDTH, w);
		write_reg(REG_GLYPH_HEIGHT, h);
		write_reg(REG_GLYPH_COUNT, count);
		write_reg(REG_BYTES_PER_GLYPH, bytes);
		write_reg(REG_LINE_PITCH, lp);
		write_reg(REG_SCREEN_WIDTH, swid);
		write_reg(REG_SCREEN_HEIGHT, shgt);
		write_reg(REG_BACKGROUND_COLOR, bgc);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// drops and row-less characters can still be in flight when the queue empties
	task settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_rows.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task set_idle(int mode);
		case (mode)
			1: begin
				send_idle_pct = 59;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 59;
			end
			3: begin
				send_idle_pct = 38;
				stall_pct = 38;
			end
			default: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// mostly glyphs from a small pool, so font loading stays short
	task random_stream(int n);
		int       done, pick, sub;
		bit [7:0] code;
		bit       cheap;
		done = 0;
		for (int i = 0; i < 6; i++)
			glyph_pool[i] = $urandom_range(255);
		cheap = (sb.row_count() * ((sb.glyph_px() + 7) / 8) <= 8);
		while (done < n) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				sub = $urandom_range(9);
				if (sub == 0)
					code = ctrl_codes[$urandom_range(3)];
				else if (sub >= 8 && cheap)
					code = $urandom_range(255);
				else
					code = glyph_pool[$urandom_range(5)];
				type_char(code);
				done++;
			end else if (pick < 72) begin
				if ($urandom_range(1))
					set_cursor($urandom_range(clip8(sb.col_limit())),
						$urandom_range(clip8(sb.line_limit())));
				else
					set_cursor($urandom_range(255), $urandom_range(255));
				done++;
			end else if (pick < 94) begin
				load_byte($urandom_range(FONT_BYTES_DEF - 1), $urandom_range(255));
				done++;
			end else begin
				odd_command();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset register values
		set_idle(0);
		type_char(8'h41);
		type_char(CH_BS);
		type_char(CH_BS);
		type_char(8'h41);
		type_char(CH_DEL);
		set_cursor(5, 3);
		type_char(CH_CR);
		type_char(8'h41);
		type_char(CH_LF);
		type_char(8'h41);
		set_cursor(sb.col_limit() - 1, 2);
		type_char(8'h41);
		set_cursor(sb.col_limit() - 1, sb.line_limit() - 1);
		type_char(8'h41);
		set_cursor(255, 255);
		type_char(CH_LF);
		odd_command();
		settle();

		configure(5, 3, 40, 3, 640, 60, 40, $urandom);
		set_idle(1);
		random_stream(20);
		settle();

		configure(16, 32, 256, 64, 65535, 4095, 4095, 32'hffff_ffff);
		set_idle(2);
		random_stream(15);
		settle();

		// tiny glyphs on a huge screen: cursor wraps modulo 256
		configure(0, 1, 1, 1, 4, 4095, 4095, 32'h0);
		set_idle(3);
		set_cursor(255, 7);
		type_char(8'h00);
		type_char(8'hff);
		set_cursor(3, 255);
		type_char(CH_LF);
		type_char(8'h20);
		random_stream(20);
		settle();

		// oversize width and height, row offsets past 2^28
		configure(31, 63, 300, 127, 65535, 4095, 4095, $urandom);
		set_idle(0);
		set_cursor(0, 200);
		type_char(8'h5a);
		random_stream(12);
		settle();

		// zero height: nothing drawn, cursor still moves
		configure(7, 0, 128, 8, 1000, 1, 300, $urandom);
		set_idle(1);
		random_stream(8);
		settle();

		configure(12, 8, 200, 16, 2048, 640, 90, $urandom);
		set_idle(2);
		set_cursor(0, 0);
		type_char(8'hfa);
		random_stream(20);
		settle();

		configure(3, 5, 511, 5, 100, 50, 30, $urandom);
		set_idle(3);
		random_stream(15);
		settle();

		if (sb.mismatches == 0)
			$display("PASS text_console_glyph_renderer_top");
		else
			$display("FAIL text_console_glyph_renderer_top");
		$finish;
	end

endmodule
